// File: rtl/core/l1ogs_pkg.sv
// ---------------------------------------------------------------------------
// L1 offset grid search package
// Shared widths, register codes, sequencer states and divider interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package l1ogs_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int SAMPLE_W   = 16;
	localparam int OFF_W      = 24;
	localparam int SUM_W      = 40;
	localparam int MEAN_W     = 23;
	localparam int STEP_W     = 12;
	localparam int SIDE_W     = 10;
	localparam int PROD_W     = STEP_W + SIDE_W;
	localparam int TRY_W      = SIDE_W + 1;
	localparam int DIVCNT_W   = $clog2(SUM_W);
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(20);
	localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(500);
	localparam logic [MEAN_W-1:0] MEAN_MAX   = {MEAN_W{1'b1}};

	// Register select, taken from paddr[2].
	localparam logic REG_STEP = 1'b0;
	localparam logic REG_SIDE = 1'b1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_GUESS_RD,
		ST_GUESS_WAIT,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN,
		ST_CMP,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [SUM_W-1:0]  quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/l1ogs_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module l1ogs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/l1ogs_div.sv
// ---------------------------------------------------------------------------
// Restoring divider
// Divides the residual sum by the pair count, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module l1ogs_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire l1ogs_pkg::div_req_t req,
	output l1ogs_pkg::div_rsp_t      rsp
);

	logic                            busy_q;
	logic                            done_q;
	logic [l1ogs_pkg::DIVCNT_W-1:0]  cnt_q;
	logic [l1ogs_pkg::CNT_W-1:0]     rem_q;
	logic [l1ogs_pkg::SUM_W-1:0]     quo_q;
	logic [l1ogs_pkg::CNT_W:0]       part;
	logic [l1ogs_pkg::CNT_W:0]       diff;
	logic                            ge;

	always_comb begin
		part = {rem_q, quo_q[l1ogs_pkg::SUM_W-1]};
		diff = part - {1'b0, req.divisor};
		ge   = part >= {1'b0, req.divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + l1ogs_pkg::DIVCNT_W'(1);
				if (cnt_q == l1ogs_pkg::DIVCNT_W'(l1ogs_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[l1ogs_pkg::SUM_W-2:0], ge};
			rem_q <= ge ? diff[l1ogs_pkg::CNT_W-1:0] : part[l1ogs_pkg::CNT_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// File: rtl/core/l1_offset_grid_search_top.sv
// ---------------------------------------------------------------------------
// L1 offset grid search, top level
// Stores template/data pairs, then scans a grid of offsets for the least
// sum of absolute residuals and reports the winning offset and mean residual.
// ---------------------------------------------------------------------------
// Usage: pairs arrive on the sample channel (sample_valid/sample_stall), one
// transfer per cycle while the block is loading. Up to 4096 pairs are kept in
// an on-chip RAM; further pairs are dropped and reported through overflow.
// The transfer that carries last starts the search, and sample_stall stays
// high until the search has finished and its result has been moved into the
// output register.
// The search tries 2*S offsets. Each try streams every stored pair through a
// single subtract/absolute/accumulate datapath, one pair per cycle, followed by
// the pipeline drain and the compare. A restoring divider then forms the mean
// in 40 steps. With S = 0 no offset is tried, the mean is zero and the result
// follows the setup directly.
// The result is held on the result channel until a transfer with
// result_stall low. While it waits, the next set of pairs can already load;
// a second result waits in the sequencer until the output register frees.
// Reset returns the registers to step 20 and 500 steps per side and empties
// the pair set. The RAM needs no clearing pass; only entries of the current
// set are ever read.
// ---------------------------------------------------------------------------
`default_nettype none

module l1_offset_grid_search_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [l1ogs_pkg::APB_AW-1:0]        paddr,
	input  wire logic [l1ogs_pkg::APB_DW-1:0]        pwdata,
	output logic      [l1ogs_pkg::APB_DW-1:0]        prdata,
	output logic                                     pready,
	// Sample channel
	input  wire logic                                sample_valid,
	output logic                                     sample_stall,
	input  wire logic signed [l1ogs_pkg::SAMPLE_W-1:0] template_sample,
	input  wire logic signed [l1ogs_pkg::SAMPLE_W-1:0] data_sample,
	input  wire logic                                last,
	// Result channel
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic signed [l1ogs_pkg::OFF_W-1:0]       best_offset,
	output logic      [l1ogs_pkg::MEAN_W-1:0]        mean_residual,
	output logic      [l1ogs_pkg::CNT_W-1:0]         point_count,
	output logic                                     overflow
);

	localparam int PAD_W = l1ogs_pkg::OFF_W + 1 - l1ogs_pkg::SAMPLE_W;
	localparam int GPAD_W = l1ogs_pkg::OFF_W - l1ogs_pkg::SAMPLE_W - 1;

	// Configuration registers.
	logic [l1ogs_pkg::STEP_W-1:0] step_q;
	logic [l1ogs_pkg::SIDE_W-1:0] side_q;

	// Sequencer and pair set.
	l1ogs_pkg::state_t            state_q;
	l1ogs_pkg::state_t            state_d;
	logic [l1ogs_pkg::CNT_W-1:0]  count_q;
	logic                         drop_q;
	logic [l1ogs_pkg::CNT_W-1:0]  addr_q;
	logic [l1ogs_pkg::TRY_W-1:0]  tries_q;

	// Search datapath.
	logic signed [l1ogs_pkg::SAMPLE_W:0] guess_q;
	logic [l1ogs_pkg::PROD_W-1:0]  prod_q;
	logic [l1ogs_pkg::OFF_W-1:0]   trial_q;
	logic [l1ogs_pkg::OFF_W-1:0]   best_off_q;
	logic [l1ogs_pkg::SUM_W-1:0]   best_sum_q;
	logic [l1ogs_pkg::SUM_W-1:0]   run_sum_q;
	logic                          valid_s1;
	logic                          valid_s2;
	logic [l1ogs_pkg::OFF_W-1:0]   absdiff_s2;

	// Output register.
	logic                          out_valid_q;
	logic                          out_load;

	// RAM and divider connections.
	logic                          ram_we;
	logic [l1ogs_pkg::ADDR_W-1:0]  ram_raddr;
	logic [2*l1ogs_pkg::SAMPLE_W-1:0] ram_rdata;
	logic [l1ogs_pkg::SAMPLE_W-1:0] rd_t;
	logic [l1ogs_pkg::SAMPLE_W-1:0] rd_d;
	l1ogs_pkg::div_req_t           div_req;
	l1ogs_pkg::div_rsp_t           div_rsp;

	logic                          sample_xfer;
	logic                          cfg_write;
	logic                          scan_end;
	logic [l1ogs_pkg::OFF_W:0]     diff_c;
	logic [l1ogs_pkg::OFF_W:0]     absdiff_c;
	logic [l1ogs_pkg::MEAN_W-1:0]  mean_c;

	assign pready       = 1'b1;
	assign sample_stall = (state_q != l1ogs_pkg::ST_LOAD);
	assign sample_xfer  = sample_valid && !sample_stall;
	assign cfg_write    = psel && penable && pwrite && pready;

	// Configuration write and read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= l1ogs_pkg::STEP_RESET;
			side_q <= l1ogs_pkg::SIDE_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				l1ogs_pkg::REG_STEP: step_q <= pwdata[l1ogs_pkg::STEP_W-1:0];
				default:             side_q <= pwdata[l1ogs_pkg::SIDE_W-1:0];
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			l1ogs_pkg::REG_STEP: prdata = l1ogs_pkg::APB_DW'(step_q);
			default:             prdata = l1ogs_pkg::APB_DW'(side_q);
		endcase
	end

	// Pair store: template in the upper half, data in the lower half.
	assign ram_we = sample_xfer && !count_q[l1ogs_pkg::CNT_W-1];
	assign ram_raddr = (state_q == l1ogs_pkg::ST_GUESS_RD) ?
		count_q[l1ogs_pkg::CNT_W-1:1] : addr_q[l1ogs_pkg::ADDR_W-1:0];

	l1ogs_ram #(
		.WIDTH (2 * l1ogs_pkg::SAMPLE_W),
		.DEPTH (l1ogs_pkg::MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[l1ogs_pkg::ADDR_W-1:0]),
		.wdata ({template_sample, data_sample}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_t = ram_rdata[2*l1ogs_pkg::SAMPLE_W-1:l1ogs_pkg::SAMPLE_W];
	assign rd_d = ram_rdata[l1ogs_pkg::SAMPLE_W-1:0];

	assign div_req.start    = (state_q == l1ogs_pkg::ST_DIV_START);
	assign div_req.dividend = best_sum_q;
	assign div_req.divisor  = count_q;

	l1ogs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// The last read of a try is issued when the address reaches n-1.
	assign scan_end = (addr_q == count_q - l1ogs_pkg::CNT_W'(1));

	// Residual of one pair against the current trial offset.
	always_comb begin
		diff_c = {{PAD_W{rd_t[l1ogs_pkg::SAMPLE_W-1]}}, rd_t}
			+ {trial_q[l1ogs_pkg::OFF_W-1], trial_q}
			- {{PAD_W{rd_d[l1ogs_pkg::SAMPLE_W-1]}}, rd_d};
		absdiff_c = diff_c[l1ogs_pkg::OFF_W] ? (~diff_c + (l1ogs_pkg::OFF_W+1)'(1)) : diff_c;
	end

	// With no trial the mean is zero; otherwise the quotient, saturated.
	always_comb begin
		if (side_q == '0) begin
			mean_c = '0;
		end else if (div_rsp.quotient[l1ogs_pkg::SUM_W-1:l1ogs_pkg::MEAN_W] != '0) begin
			mean_c = l1ogs_pkg::MEAN_MAX;
		end else begin
			mean_c = div_rsp.quotient[l1ogs_pkg::MEAN_W-1:0];
		end
	end

	// Next state.
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			l1ogs_pkg::ST_LOAD: begin
				if (sample_xfer && last) begin
					state_d = l1ogs_pkg::ST_GUESS_RD;
				end
			end
			l1ogs_pkg::ST_GUESS_RD:   state_d = l1ogs_pkg::ST_GUESS_WAIT;
			l1ogs_pkg::ST_GUESS_WAIT: state_d = l1ogs_pkg::ST_SETUP;
			l1ogs_pkg::ST_SETUP: begin
				state_d = (side_q == '0) ? l1ogs_pkg::ST_DONE : l1ogs_pkg::ST_SCAN;
			end
			l1ogs_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = l1ogs_pkg::ST_DRAIN;
				end
			end
			l1ogs_pkg::ST_DRAIN: begin
				if (!valid_s1 && !valid_s2) begin
					state_d = l1ogs_pkg::ST_CMP;
				end
			end
			l1ogs_pkg::ST_CMP: begin
				state_d = (tries_q == l1ogs_pkg::TRY_W'(1)) ?
					l1ogs_pkg::ST_DIV_START : l1ogs_pkg::ST_SCAN;
			end
			l1ogs_pkg::ST_DIV_START: state_d = l1ogs_pkg::ST_DIV_WAIT;
			l1ogs_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = l1ogs_pkg::ST_DONE;
				end
			end
			l1ogs_pkg::ST_DONE: begin
				if (!out_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = l1ogs_pkg::ST_LOAD;
				end
			end
			default: state_d = l1ogs_pkg::ST_LOAD;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= l1ogs_pkg::ST_LOAD;
			count_q     <= '0;
			drop_q      <= 1'b0;
			addr_q      <= '0;
			tries_q     <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == l1ogs_pkg::ST_SCAN);
			valid_s2 <= valid_s1;

			if (sample_xfer) begin
				if (count_q[l1ogs_pkg::CNT_W-1]) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + l1ogs_pkg::CNT_W'(1);
				end
			end

			case (state_q)
				l1ogs_pkg::ST_SETUP: begin
					tries_q <= {side_q, 1'b0};
					addr_q  <= '0;
				end
				l1ogs_pkg::ST_SCAN: addr_q <= addr_q + l1ogs_pkg::CNT_W'(1);
				l1ogs_pkg::ST_CMP: begin
					tries_q <= tries_q - l1ogs_pkg::TRY_W'(1);
					addr_q  <= '0;
				end
				default: begin
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				drop_q      <= 1'b0;
			end else if (result_valid && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		absdiff_s2 <= absdiff_c[l1ogs_pkg::OFF_W-1:0];
		if (valid_s2) begin
			run_sum_q <= run_sum_q + l1ogs_pkg::SUM_W'(absdiff_s2);
		end

		case (state_q)
			l1ogs_pkg::ST_GUESS_WAIT: begin
				guess_q <= $signed({rd_d[l1ogs_pkg::SAMPLE_W-1], rd_d})
					- $signed({rd_t[l1ogs_pkg::SAMPLE_W-1], rd_t});
				prod_q  <= l1ogs_pkg::PROD_W'(side_q) * l1ogs_pkg::PROD_W'(step_q);
			end
			l1ogs_pkg::ST_SETUP: begin
				trial_q    <= {{GPAD_W{guess_q[l1ogs_pkg::SAMPLE_W]}}, guess_q}
					- l1ogs_pkg::OFF_W'(prod_q);
				best_off_q <= {{GPAD_W{guess_q[l1ogs_pkg::SAMPLE_W]}}, guess_q}
					- l1ogs_pkg::OFF_W'(prod_q);
				best_sum_q <= '1;
				run_sum_q  <= '0;
			end
			l1ogs_pkg::ST_CMP: begin
				if (run_sum_q < best_sum_q) begin
					best_sum_q <= run_sum_q;
					best_off_q <= trial_q;
				end
				trial_q   <= trial_q + l1ogs_pkg::OFF_W'(step_q);
				run_sum_q <= '0;
			end
			default: begin
			end
		endcase

		if (out_load) begin
			best_offset   <= best_off_q;
			mean_residual <= mean_c;
			point_count   <= count_q;
			overflow      <= drop_q;
		end
	end

	assign result_valid = out_valid_q;

endmodule

`default_nettype wire
